// File: src/htfd_pkg.sv
// Shared types, constants and the CRC-8 step for the sensor frame decoder.
`default_nettype none
package htfd_pkg;

  localparam logic [7:0]  CrcInit    = 8'hFF;
  localparam logic [7:0]  CrcPoly    = 8'h31;

  // byte positions within one six-byte frame
  localparam logic [2:0]  PosTempHi  = 3'd0;
  localparam logic [2:0]  PosTempLo  = 3'd1;
  localparam logic [2:0]  PosTempCrc = 3'd2;
  localparam logic [2:0]  PosHumHi   = 3'd3;
  localparam logic [2:0]  PosHumLo   = 3'd4;
  localparam logic [2:0]  PosHumCrc  = 3'd5;

  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [13:0] HumScale   = 14'd10000;
  localparam logic [14:0] TempOffset = 15'd4500;
  // in-range limits on the unscaled quotient: -40.00 and 125.00 degrees
  localparam logic [14:0] TempLowQ   = 15'd500;
  localparam logic [14:0] TempHighQ  = 15'd17000;

  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_ok;
    logic        hum_ok;
  } frame_t;

  typedef struct packed {
    logic              in_range;
    logic              hum_crc_ok;
    logic              temp_crc_ok;
    logic [13:0]       humidity_centi;
    logic signed [14:0] temperature_centi;
  } result_t;

  // one byte of CRC-8, MSB first, poly 0x31
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/htfd_frame.sv
// Input register, byte position tracking, word assembly and CRC checking.
`default_nettype none
module htfd_frame (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            in_start_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output htfd_pkg::frame_t     out_o
);
  import htfd_pkg::*;

  logic        a_v_q;
  logic [7:0]  a_byte_q;
  logic        a_start_q;
  logic        b_v_q;
  frame_t      b_q;

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_q, temp_d;
  logic [15:0] hum_q, hum_d;
  logic        tok_q, tok_d;
  logic        done;
  logic        en_b;
  logic        consume;

  assign en_b       = !b_v_q || out_ready_i;
  assign consume    = a_v_q && en_b;
  assign in_ready_o = !a_v_q || en_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (in_ready_o) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_byte_q  <= in_byte_i;
      a_start_q <= in_start_i;
    end
  end

  always_comb begin
    pos    = (a_start_q || pos_q > PosHumCrc) ? PosTempHi : pos_q;
    pos_d  = pos + 3'd1;
    crc_d  = crc_q;
    temp_d = temp_q;
    hum_d  = hum_q;
    tok_d  = tok_q;
    done   = 1'b0;
    case (pos)
      PosTempHi: begin
        temp_d = {a_byte_q, 8'h00};
        crc_d  = crc8_byte(CrcInit, a_byte_q);
      end
      PosTempLo: begin
        temp_d = {temp_q[15:8], a_byte_q};
        crc_d  = crc8_byte(crc_q, a_byte_q);
      end
      PosTempCrc: begin
        tok_d = (crc_q == a_byte_q);
      end
      PosHumHi: begin
        hum_d = {a_byte_q, 8'h00};
        crc_d = crc8_byte(CrcInit, a_byte_q);
      end
      PosHumLo: begin
        hum_d = {hum_q[15:8], a_byte_q};
        crc_d = crc8_byte(crc_q, a_byte_q);
      end
      default: begin
        done  = 1'b1;
        pos_d = PosTempHi;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosTempHi;
      crc_q  <= CrcInit;
      temp_q <= 16'h0000;
      hum_q  <= 16'h0000;
      tok_q  <= 1'b0;
    end else if (consume) begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      temp_q <= temp_d;
      hum_q  <= hum_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_b) begin
      b_v_q <= consume && done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && done) begin
      b_q.temp_word <= temp_q;
      b_q.hum_word  <= hum_q;
      b_q.temp_ok   <= tok_q;
      b_q.hum_ok    <= (crc_q == a_byte_q);
    end
  end

  assign out_valid_o = b_v_q;
  assign out_o       = b_q;

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosHumCrc) else $error("byte position out of frame");
  a_done_issues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && done |=> b_v_q) else $error("frame end gave no result");
  a_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_v_q && !out_ready_i |=> b_v_q && $stable(b_q)) else $error("stalled frame lost");
`endif

endmodule
`default_nettype wire

// File: src/htfd_conv.sv
// Scaling of the raw words to hundredths, range check and output register.
`default_nettype none
module htfd_conv (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire htfd_pkg::frame_t in_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output htfd_pkg::result_t    out_o
);
  import htfd_pkg::*;

  logic        c_v_q;
  logic [30:0] tprod_q;
  logic [29:0] hprod_q;
  logic        tok_q, hok_q;
  logic        o_v_q;
  result_t     o_q;

  logic        en_c, en_o;
  logic [31:0] t_sum;
  logic [30:0] h_sum;
  logic [14:0] t_quo;
  logic [13:0] h_quo;

  assign en_o       = !o_v_q || out_ready_i;
  assign en_c       = !c_v_q || en_o;
  assign in_ready_o = en_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en_c) begin
      c_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c && in_valid_i) begin
      tprod_q <= 31'(in_i.temp_word) * 31'(TempScale);
      hprod_q <= 30'(in_i.hum_word) * 30'(HumScale);
      tok_q   <= in_i.temp_ok;
      hok_q   <= in_i.hum_ok;
    end
  end

  // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 while the quotient stays below 65536
  assign t_sum = {1'b0, tprod_q} + 32'(tprod_q[30:16]) + 32'd1;
  assign h_sum = {1'b0, hprod_q} + 31'(hprod_q[29:16]) + 31'd1;
  assign t_quo = t_sum[30:16];
  assign h_quo = h_sum[29:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (en_o) begin
      o_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && c_v_q) begin
      o_q.temperature_centi <= $signed(t_quo - TempOffset);
      o_q.humidity_centi    <= h_quo;
      o_q.temp_crc_ok       <= tok_q;
      o_q.hum_crc_ok        <= hok_q;
      o_q.in_range          <= (t_quo >= TempLowQ) && (t_quo <= TempHighQ);
    end
  end

  assign out_valid_o = o_v_q;
  assign out_o       = o_q;

`ifndef SYNTH
  a_c_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_v_q && !en_o |=> c_v_q && $stable(tprod_q) && $stable(hprod_q))
    else $error("product stage lost while stalled");
`endif

endmodule
`default_nettype wire

// File: src/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature sensor frame decoder.
//
//  channel  dir  tdata (low bit up)                                   tuser
//  s_axis   in   data_byte[7:0]                                       frame_start
//  m_axis   out  temperature_centi[14:0] humidity_centi[28:15]        -
//                temp_crc_ok[29] hum_crc_ok[30] in_range[31]
//
// One byte is taken every cycle unless a stall holds s_axis_tready low; the sixth
// byte of a frame yields one item. The result is offered once that byte has passed
// the input register, frame register, product register and output register.
// Reset is asynchronous and active low; it clears the frame state and valids.
// A stall on m_axis fills the stages behind it one by one before s_axis_tready drops.
`default_nettype none
module humidity_temp_frame_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // temperature_centi, humidity_centi,
                                           // temp_crc_ok, hum_crc_ok, in_range
);
  import htfd_pkg::*;

  frame_t  frame;
  logic    frame_valid;
  logic    frame_ready;
  result_t result;

  htfd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (frame_valid),
    .out_ready_i (frame_ready),
    .out_o       (frame)
  );

  htfd_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_valid),
    .in_i        (frame),
    .in_ready_o  (frame_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = {result.in_range, result.hum_crc_ok, result.temp_crc_ok,
                         result.humidity_centi, result.temperature_centi};

endmodule
`default_nettype wire
